### sv/owrs_pkg.sv
// Shared types, command and status codes for the 1-Wire ROM search block.
`default_nettype none

package owrs_pkg;

  // Default ROM code length in bytes (1 to 8)
  localparam int ROM_BYTES_DEFAULT = 8;

  // Fixed field widths
  localparam int ROM_W    = 64;
  localparam int POS_W    = 7;
  localparam int FAM_W    = 4;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;

  // Discrepancies below this position fall inside the family byte
  localparam logic [POS_W-1:0] FAMILY_LIMIT = 7'd9;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BITS  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BEGUN   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TAKEN   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FAILED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NO_MORE = 3'd5;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd6;

  // One request as held in the input register
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             no_presence;
    logic             id_bit;
    logic             complement_bit;
  } req_t;

  // One result as held in the output register
  typedef struct packed {
    logic                write_bit;
    logic [STATUS_W-1:0] status;
    logic [ROM_W-1:0]    rom_code;
    logic [POS_W-1:0]    last_discrepancy;
    logic [FAM_W-1:0]    family_discrepancy;
    logic                last_device;
  } rsp_t;

endpackage

`default_nettype wire

### sv/owrs_core.sv
// Search state registers and the per-request search step logic.
`default_nettype none

module owrs_core
  import owrs_pkg::*;
#(
  parameter int ROM_BYTES = ROM_BYTES_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic fire,
  input  wire req_t req,
  output rsp_t      rsp
);

  localparam logic [POS_W-1:0] TOTAL_BITS = POS_W'(ROM_BYTES * 8);

  // Search state
  logic [ROM_W-1:0] rom_register;
  logic [POS_W-1:0] last_discrepancy;
  logic [FAM_W-1:0] family_discrepancy;
  logic             last_device;
  logic [POS_W-1:0] bit_position;
  logic [POS_W-1:0] last_zero_position;
  logic             pass_active;

  logic [ROM_W-1:0] rom_register_next;
  logic [POS_W-1:0] last_discrepancy_next;
  logic [FAM_W-1:0] family_discrepancy_next;
  logic             last_device_next;
  logic [POS_W-1:0] bit_position_next;
  logic [POS_W-1:0] last_zero_position_next;
  logic             pass_active_next;

  logic [5:0]          idx;
  logic                dir;
  logic [POS_W-1:0]    pos_inc;
  logic [ROM_W-1:0]    rom_bit_set;
  logic [STATUS_W-1:0] status;
  logic                wbit;

  assign idx = 6'(bit_position - POS_W'(1));
  assign pos_inc = bit_position + POS_W'(1);

  // Direction: forced by the line, else follow the previous path below the last discrepancy, take 1 at it and 0 beyond
  always_comb begin
    if (req.id_bit != req.complement_bit) begin
      dir = req.id_bit;
    end else if (bit_position < last_discrepancy) begin
      dir = rom_register[idx];
    end else begin
      dir = (bit_position == last_discrepancy);
    end
  end

  always_comb begin
    rom_bit_set = rom_register;
    rom_bit_set[idx] = dir;
  end

  // Next state and result for one request
  always_comb begin
    rom_register_next       = rom_register;
    last_discrepancy_next   = last_discrepancy;
    family_discrepancy_next = family_discrepancy;
    last_device_next        = last_device;
    bit_position_next       = bit_position;
    last_zero_position_next = last_zero_position;
    pass_active_next        = pass_active;
    status                  = ST_IGNORED;
    wbit                    = 1'b0;
    case (req.command)
      CMD_CLEAR: begin
        last_discrepancy_next   = '0;
        family_discrepancy_next = '0;
        last_device_next        = 1'b0;
        pass_active_next        = 1'b0;
        bit_position_next       = POS_W'(1);
        last_zero_position_next = '0;
        status                  = ST_CLEARED;
      end
      CMD_BEGIN: begin
        bit_position_next       = POS_W'(1);
        last_zero_position_next = '0;
        if (last_device || req.no_presence) begin
          last_discrepancy_next   = '0;
          family_discrepancy_next = '0;
          last_device_next        = 1'b0;
          pass_active_next        = 1'b0;
          status = last_device ? ST_NO_MORE : ST_FAILED;
        end else begin
          pass_active_next = 1'b1;
          status           = ST_BEGUN;
        end
      end
      CMD_BITS: begin
        if (pass_active) begin
          if (req.id_bit && req.complement_bit) begin
            last_discrepancy_next   = '0;
            family_discrepancy_next = '0;
            last_device_next        = 1'b0;
            pass_active_next        = 1'b0;
            bit_position_next       = POS_W'(1);
            last_zero_position_next = '0;
            status                  = ST_FAILED;
          end else begin
            // zero picked at a discrepancy
            if ((req.id_bit == req.complement_bit) && !dir) begin
              last_zero_position_next = bit_position;
              if (bit_position < FAMILY_LIMIT) begin
                family_discrepancy_next = FAM_W'(bit_position);
              end
            end
            rom_register_next = rom_bit_set;
            wbit              = dir;
            bit_position_next = pos_inc;
            status            = ST_TAKEN;
            // pass complete
            if (pos_inc > TOTAL_BITS) begin
              pass_active_next      = 1'b0;
              bit_position_next     = POS_W'(1);
              last_discrepancy_next = last_zero_position_next;
              if (last_zero_position_next == '0) begin
                last_device_next = 1'b1;
              end
              if (rom_bit_set[7:0] == 8'd0) begin
                last_discrepancy_next   = '0;
                family_discrepancy_next = '0;
                last_device_next        = 1'b0;
                last_zero_position_next = '0;
                status                  = ST_FAILED;
              end else begin
                status = ST_FOUND;
              end
            end
          end
        end
      end
      default: begin
        status = ST_IGNORED;
      end
    endcase
  end

  // State update on each request that moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_register       <= '0;
      last_discrepancy   <= '0;
      family_discrepancy <= '0;
      last_device        <= 1'b0;
      bit_position       <= POS_W'(1);
      last_zero_position <= '0;
      pass_active        <= 1'b0;
    end else if (fire) begin
      rom_register       <= rom_register_next;
      last_discrepancy   <= last_discrepancy_next;
      family_discrepancy <= family_discrepancy_next;
      last_device        <= last_device_next;
      bit_position       <= bit_position_next;
      last_zero_position <= last_zero_position_next;
      pass_active        <= pass_active_next;
    end
  end

  assign rsp.write_bit          = wbit;
  assign rsp.status             = status;
  assign rsp.rom_code           = rom_register_next;
  assign rsp.last_discrepancy   = last_discrepancy_next;
  assign rsp.family_discrepancy = family_discrepancy_next;
  assign rsp.last_device        = last_device_next;

  // Checks
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (bit_position != '0) && (bit_position <= TOTAL_BITS))
    else $error("bit position out of range");

  a_idle_pos: assert property (@(posedge clk) disable iff (rst)
    !pass_active |-> (bit_position == POS_W'(1)))
    else $error("bit position not rewound outside a pass");

  a_ld_range: assert property (@(posedge clk) disable iff (rst)
    last_discrepancy <= TOTAL_BITS)
    else $error("last discrepancy out of range");

  a_found_ends: assert property (@(posedge clk) disable iff (rst)
    (fire && (status == ST_FOUND)) |=> !pass_active)
    else $error("pass still active after found");

  a_fam_range: assert property (@(posedge clk) disable iff (rst)
    FAMILY_LIMIT > POS_W'(family_discrepancy))
    else $error("family discrepancy out of range");

endmodule

`default_nettype wire

### sv/one_wire_rom_search.sv
// Top level of the 1-Wire ROM search accelerator: request and result registers.
`default_nettype none

// 1-Wire Search ROM engine. Each request (clear, begin pass with presence
// result, or one id/complement bit pair) yields exactly one result carrying
// the direction bit to write, a status code and the search state after the
// request. A request passes through the input register and then the result
// register, and one request is taken every cycle while the result side does
// not stall; the search state updates as a request moves into the result
// register, which lets the next request use it.
// Bit-slot timing on the wire is handled outside this block.
module one_wire_rom_search
  import owrs_pkg::*;
#(
  parameter int ROM_BYTES = ROM_BYTES_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire logic [CMD_W-1:0]    command,
  input  wire logic                no_presence,
  input  wire logic                id_bit,
  input  wire logic                complement_bit,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      logic                write_bit,
  output      logic [STATUS_W-1:0] status,
  output      logic [ROM_W-1:0]    rom_code,
  output      logic [POS_W-1:0]    last_discrepancy_out,
  output      logic [FAM_W-1:0]    family_discrepancy_out,
  output      logic                last_device_out
);

  logic s1_valid;
  req_t s1_req;
  rsp_t out_rsp;
  rsp_t rsp;
  logic advance;
  logic fire;

  // Pipeline flow control
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign fire     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  // Request register
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req.command        <= command;
      s1_req.no_presence    <= no_presence;
      s1_req.id_bit         <= id_bit;
      s1_req.complement_bit <= complement_bit;
    end
  end

  owrs_core #(
    .ROM_BYTES(ROM_BYTES)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .fire(fire),
    .req (s1_req),
    .rsp (rsp)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (fire) begin
      out_rsp <= rsp;
    end
  end

  assign write_bit              = out_rsp.write_bit;
  assign status                 = out_rsp.status;
  assign rom_code               = out_rsp.rom_code;
  assign last_discrepancy_out   = out_rsp.last_discrepancy;
  assign family_discrepancy_out = out_rsp.family_discrepancy;
  assign last_device_out        = out_rsp.last_device;

endmodule

`default_nettype wire

### bench/tb_one_wire_rom_search.sv
// Testbench for the 1-Wire ROM search block: simulated buses of devices, prediction, checking.
module tb_one_wire_rom_search;
  import owrs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_BITS = ROM_BYTES_DEFAULT * 8;
  localparam int RANDOM_TARGET = 900;
  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_PRINTED = 30;
  // unused command code, the block ignores it
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_BURSTS} stall_mode_t;

  // Search state tracker and queue of results still owed by the block
  class rom_search_scoreboard;
    logic [ROM_W-1:0] rom_bits;
    logic [POS_W-1:0] last_disc;
    logic [FAM_W-1:0] fam_disc;
    logic             last_dev;
    logic [POS_W-1:0] bit_pos;
    logic [POS_W-1:0] zero_pos;
    logic             in_pass;
    rsp_t             pending_results[$];
    int               errors;

    function new();
      rom_bits = '0;
      errors = 0;
      clear_search();
    endfunction

    function void clear_search();
      last_disc = '0;
      fam_disc = '0;
      last_dev = 1'b0;
      in_pass = 1'b0;
      bit_pos = 7'd1;
      zero_pos = '0;
    endfunction

    // Advance the search state for one accepted request, queue its result
    function rsp_t note_request(req_t r);
      rsp_t       e;
      logic       dir;
      logic [5:0] idx;
      e = '0;
      e.status = ST_IGNORED;
      case (r.command)
        CMD_CLEAR: begin
          clear_search();
          e.status = ST_CLEARED;
        end
        CMD_BEGIN: begin
          if (last_dev) begin
            clear_search();
            e.status = ST_NO_MORE;
          end else if (r.no_presence) begin
            clear_search();
            e.status = ST_FAILED;
          end else begin
            in_pass = 1'b1;
            bit_pos = 7'd1;
            zero_pos = '0;
            e.status = ST_BEGUN;
          end
        end
        CMD_BITS: begin
          if (in_pass) begin
            if (r.id_bit && r.complement_bit) begin
              // nobody answered: abandon the search
              clear_search();
              e.status = ST_FAILED;
            end else begin
              idx = 6'(bit_pos - 7'd1);
              if (r.id_bit != r.complement_bit) begin
                dir = r.id_bit;
              end else begin
                // discrepancy: follow the previous path, take 1 at the last fork
                if (bit_pos < last_disc) dir = rom_bits[idx];
                else dir = (bit_pos == last_disc);
                if (!dir) begin
                  zero_pos = bit_pos;
                  if (zero_pos < FAMILY_LIMIT) fam_disc = FAM_W'(zero_pos);
                end
              end
              rom_bits[idx] = dir;
              e.write_bit = dir;
              bit_pos = bit_pos + 7'd1;
              if (bit_pos > TOTAL_BITS) begin
                in_pass = 1'b0;
                bit_pos = 7'd1;
                last_disc = zero_pos;
                if (last_disc == 0) last_dev = 1'b1;
                // a zero family code is not a real device
                if (rom_bits[7:0] == 8'd0) begin
                  clear_search();
                  e.status = ST_FAILED;
                end else begin
                  e.status = ST_FOUND;
                end
              end else begin
                e.status = ST_TAKEN;
              end
            end
          end
        end
        default: ;
      endcase
      e.rom_code = rom_bits;
      e.last_discrepancy = last_disc;
      e.family_discrepancy = fam_disc;
      e.last_device = last_dev;
      pending_results.push_back(e);
      return e;
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINTED) $display("mismatch at %0t: %s", $time, what);
    endtask

    // Compare one accepted result with the oldest outstanding one
    task check_result(rsp_t got);
      rsp_t want;
      if (pending_results.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (got.write_bit !== want.write_bit)
          report($sformatf("write_bit got %0b want %0b", got.write_bit, want.write_bit));
        if (got.status !== want.status)
          report($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.rom_code !== want.rom_code)
          report($sformatf("rom_code got %h want %h", got.rom_code, want.rom_code));
        if (got.last_discrepancy !== want.last_discrepancy)
          report($sformatf("last_discrepancy got %0d want %0d",
                           got.last_discrepancy, want.last_discrepancy));
        if (got.family_discrepancy !== want.family_discrepancy)
          report($sformatf("family_discrepancy got %0d want %0d",
                           got.family_discrepancy, want.family_discrepancy));
        if (got.last_device !== want.last_device)
          report($sformatf("last_device got %0b want %0b", got.last_device, want.last_device));
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    command = CMD_NONE;
  logic                no_presence = 1'b0;
  logic                id_bit = 1'b0;
  logic                complement_bit = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                write_bit;
  logic [STATUS_W-1:0] status;
  logic [ROM_W-1:0]    rom_code;
  logic [POS_W-1:0]    last_discrepancy_out;
  logic [FAM_W-1:0]    family_discrepancy_out;
  logic                last_device_out;

  rom_search_scoreboard sb = new();
  int          cycle_count = 0;
  int          burst_left = 0;
  int          counted_requests = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_timer = 0;
  int          stall_run = 0;

  one_wire_rom_search dut (
    .clk                    (clk),
    .rst                    (rst),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .command                (command),
    .no_presence            (no_presence),
    .id_bit                 (id_bit),
    .complement_bit         (complement_bit),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .write_bit              (write_bit),
    .status                 (status),
    .rom_code               (rom_code),
    .last_discrepancy_out   (last_discrepancy_out),
    .family_discrepancy_out (family_discrepancy_out),
    .last_device_out        (last_device_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: check accepted results, then pick the next stall value
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(rsp_t'{write_bit, status, rom_code, last_discrepancy_out,
                             family_discrepancy_out, last_device_out});
    if (stall_timer == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_timer = $urandom_range(20, 150);
    end else begin
      stall_timer--;
    end
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_COIN:     out_stall <= 1'($urandom_range(0, 1));
      STALL_PERIODIC: out_stall <= (cycle_count % 4) == 3;
      default: begin
        if (stall_run > 0) begin
          stall_run--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
          if ($urandom_range(0, 9) == 0) stall_run = $urandom_range(1, 8);
        end
      end
    endcase
  end

  // Present one request, hold it until accepted, return its predicted result
  task automatic send(input logic [CMD_W-1:0] cmd, input logic np, input logic idb,
                      input logic cmpb, output rsp_t pred);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    command <= cmd;
    no_presence <= np;
    id_bit <= idb;
    complement_bit <= cmpb;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pred = sb.note_request(req_t'{cmd, np, idb, cmpb});
    if (pred.status != ST_IGNORED) counted_requests++;
  endtask

  task automatic send_noise();
    rsp_t p;
    send(CMD_W'($urandom_range(0, 3)), 1'($urandom), 1'($urandom), 1'($urandom), p);
  endtask

  // Enumerate a simulated bus: wired-AND answers from the devices still on the path
  task automatic search_bus(input bit with_extremes);
    logic [ROM_W-1:0] devs[$];
    bit               alive[$];
    logic [ROM_W-1:0] base;
    logic             idb;
    logic             cmpb;
    rsp_t             p;
    int               n;
    int               passes;
    int               i;
    int               b;
    bit               siblings;
    bit               done;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
    siblings = $urandom_range(0, 2) == 0;
    base = {$urandom, $urandom};
    for (i = 0; i < n; i++) begin
      if (siblings) begin
        devs.push_back(base);
        devs[i][$urandom_range(0, TOTAL_BITS - 1)] ^= 1'b1;
      end else begin
        devs.push_back({$urandom, $urandom});
      end
      if ($urandom_range(0, 11) == 0) devs[i][7:0] = 8'd0;
      if ($urandom_range(0, 15) == 0) devs[i] = '1;
    end
    if (with_extremes) begin
      devs.push_back('1);
      devs.push_back({56'h00ff00ff00ff00, 8'h00});
      n += 2;
    end
    send(CMD_CLEAR, 1'($urandom), 1'($urandom), 1'($urandom), p);
    done = 1'b0;
    for (passes = 0; passes < n + 2 && !done; passes++) begin
      send(CMD_BEGIN, ($urandom_range(0, 19) == 0), 1'($urandom), 1'($urandom), p);
      if (p.status != ST_BEGUN) begin
        done = (p.status == ST_NO_MORE);
      end else begin
        alive.delete();
        for (i = 0; i < n; i++) alive.push_back(1'b1);
        for (b = 0; b < TOTAL_BITS; b++) begin
          if ($urandom_range(0, 299) == 0) begin
            // disturbance mid-pass: random request, then restart the pass
            send_noise();
            break;
          end
          idb = 1'b1;
          cmpb = 1'b1;
          for (i = 0; i < n; i++) begin
            if (alive[i]) begin
              idb &= devs[i][b];
              cmpb &= ~devs[i][b];
            end
          end
          if ($urandom_range(0, 299) == 0) begin
            idb = 1'b1;
            cmpb = 1'b1;
          end
          send(CMD_BITS, 1'($urandom), idb, cmpb, p);
          if (p.status != ST_TAKEN) break;
          for (i = 0; i < n; i++)
            if (devs[i][b] != p.write_bit) alive[i] = 1'b0;
        end
      end
    end
  endtask

  // Stimulus
  initial begin
    rsp_t p;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: every command and the corner cases of a pass
    send(CMD_NONE, 1'b1, 1'b1, 1'b1, p);
    send(CMD_BITS, 1'b0, 1'b1, 1'b0, p);
    send(CMD_CLEAR, 1'b1, 1'b1, 1'b1, p);
    send(CMD_BEGIN, 1'b1, 1'b0, 1'b0, p);
    send(CMD_BEGIN, 1'b0, 1'b0, 1'b0, p);
    send(CMD_BITS, 1'b0, 1'b1, 1'b0, p);
    send(CMD_BITS, 1'b1, 1'b0, 1'b1, p);
    send(CMD_BITS, 1'b0, 1'b0, 1'b0, p);
    send(CMD_BITS, 1'b0, 1'b1, 1'b0, p);
    // begin again in the middle of a pass
    send(CMD_BEGIN, 1'b0, 1'b1, 1'b1, p);
    send(CMD_BITS, 1'b0, 1'b0, 1'b0, p);
    // both ones ends the pass
    send(CMD_BITS, 1'b0, 1'b1, 1'b1, p);
    send(CMD_BITS, 1'b0, 1'b0, 1'b1, p);
    send(CMD_BEGIN, 1'b0, 1'b0, 1'b0, p);
    send(CMD_BITS, 1'b0, 1'b0, 1'b1, p);
    // clear abandons the pass
    send(CMD_CLEAR, 1'b0, 1'b0, 1'b0, p);
    send(CMD_BITS, 1'b1, 1'b0, 1'b1, p);
    send(CMD_NONE, 1'b0, 1'b0, 1'b0, p);

    // random: full bus enumerations with occasional loose requests
    counted_requests = 0;
    search_bus(1'b1);
    while (counted_requests < RANDOM_TARGET) begin
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 8)) send_noise();
      else search_bus(1'b0);
    end

    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
